// File: rtl/core/icc_pkg.sv
// Shared constants, codes and types for the interrupt claim controller.
// Used by icc_prio_ram, icc_scan and interrupt_controller_claim.
package icc_pkg;

  localparam int NUM_SOURCES = 32;               // claimable sources are 1 .. NUM_SOURCES-1
  localparam int PRIO_DEPTH  = 32;               // priority store, indexed by offset bits 6:2
  localparam int IDX_W       = $clog2(PRIO_DEPTH);
  localparam int CNT_W       = $clog2(NUM_SOURCES + 1);

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LINE  = 2'd2;

  localparam logic [25:0] OFF_PENDING   = 26'h0001000;
  localparam logic [25:0] OFF_ENABLE    = 26'h0002000;
  localparam logic [25:0] OFF_THRESHOLD = 26'h0200000;
  localparam logic [25:0] OFF_CLAIM     = 26'h0200004;

  // Control from the sequencer to the scan accumulator
  typedef struct packed {
    logic             clear;   // start a fresh scan
    logic             sample;  // read data for addr is present this cycle
    logic [IDX_W-1:0] addr;    // source whose priority is on the read port
    logic             cand;    // source is asserted, enabled and not in service
  } scan_ctl_t;

endpackage

// File: rtl/core/icc_prio_ram.sv
// Per-source priority store: one write port, one read port, registered read data.
// Entries not yet written read as zero through valid bits cleared at reset.
// Depends on icc_pkg.
module icc_prio_ram (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         we,
  input  logic [icc_pkg::IDX_W-1:0]    waddr,
  input  logic [31:0]                  wdata,
  input  logic                         re,
  input  logic [icc_pkg::IDX_W-1:0]    raddr,
  output logic [31:0]                  rdata
);

  logic [31:0]                    mem [icc_pkg::PRIO_DEPTH];
  logic [icc_pkg::PRIO_DEPTH-1:0] valid;
  logic [31:0]                    rdata_raw;
  logic                           rvalid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_raw <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid <= valid[raddr];
      end
    end
  end

  assign rdata = rvalid ? rdata_raw : 32'd0;

endmodule

// File: rtl/core/icc_scan.sv
// Scan accumulator: tracks the best claimable source and how many qualify.
// Fed one stored priority per cycle by the sequencer. Depends on icc_pkg.
module icc_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  icc_pkg::scan_ctl_t         ctl,
  input  logic [31:0]                prio,
  input  logic [31:0]                threshold,
  output logic [icc_pkg::IDX_W-1:0]  best,
  output logic [1:0]                 qual_cnt
);

  logic [31:0] best_prio;
  logic        qualifies;

  assign qualifies = ctl.cand && (prio > threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      best      <= '0;
      best_prio <= '0;
      qual_cnt  <= '0;
    end else if (ctl.clear) begin
      best      <= '0;
      best_prio <= '0;
      qual_cnt  <= '0;
    end else if (ctl.sample && qualifies) begin
      // saturate at two: only "one" versus "more than one" matters
      if (qual_cnt != 2'd2) begin
        qual_cnt <= qual_cnt + 2'd1;
      end
      // strict compare keeps the lowest number on a tie
      if (prio > best_prio) begin
        best      <= ctl.addr;
        best_prio <= prio;
      end
    end
  end

endmodule

// File: rtl/core/interrupt_controller_claim.sv
// Single-context interrupt controller with claim/complete, top level.
// Depends on icc_pkg, icc_prio_ram and icc_scan.
//
// Usage: each input word is a register read, a register write or a device line
// update (operation, offset, write_data, source, level), taken on in_valid &&
// in_ready. Every input word yields exactly one output word (read_data,
// irq_pending), offered on out_valid and taken on out_valid && out_ready.
// Priorities sit in a 32-entry synchronous RAM; the masks and threshold are
// registers. After applying the word, a sequencer walks sources 1 to
// NUM_SOURCES-1 through the RAM read port, one per cycle, to find the best
// claimable source and whether another remains for irq_pending.
// A priority read first passes through S_PRD to capture the registered RAM
// read data, then walks like any other word.
// A new word is taken only between walks, the cycle after the previous result
// is loaded; a loaded result may wait in the output register meanwhile.
// If the receiver stalls with a result still held, the walk finishes and
// waits to load until the output register drains.
// Reset clears all masks, the threshold and the priority valid bits, so every
// priority reads as zero; no clearing pass is needed.
module interrupt_controller_claim (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [25:0] offset,
  input  logic [31:0] write_data,
  input  logic [4:0]  source,
  input  logic        level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        irq_pending
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_PRD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]  state;
  logic [1:0]  op;
  logic [25:0] off;
  logic [31:0] wdat;
  logic [4:0]  src;
  logic        lvl;

  logic [31:0] enable_mask;
  logic [31:0] threshold;
  logic [31:0] in_service;
  logic [31:0] line_mask;
  logic [31:0] rdata;

  logic [icc_pkg::CNT_W-1:0] issue_idx;
  logic                      pv;
  logic [icc_pkg::IDX_W-1:0] paddr;

  logic                      prio_off;
  logic                      is_claim;
  logic                      out_free;
  logic                      issue_more;
  logic                      ram_we;
  logic                      ram_re;
  logic [icc_pkg::IDX_W-1:0] ram_raddr;
  logic [31:0]               ram_rdata;
  icc_pkg::scan_ctl_t        ctl;
  logic [icc_pkg::IDX_W-1:0] best;
  logic [1:0]                qual_cnt;

  assign prio_off   = (off[25:12] == 14'd0);
  assign is_claim   = (op == icc_pkg::OP_READ) && (off == icc_pkg::OFF_CLAIM);
  assign out_free   = !out_valid || out_ready;
  assign issue_more = (issue_idx < icc_pkg::CNT_W'(icc_pkg::NUM_SOURCES));
  assign in_ready   = (state == S_IDLE);

  assign ram_we    = (state == S_EXEC) && (op == icc_pkg::OP_WRITE) && prio_off;
  assign ram_re    = ((state == S_EXEC) && (op == icc_pkg::OP_READ) && prio_off) ||
                     ((state == S_SCAN) && issue_more);
  assign ram_raddr = (state == S_SCAN) ? issue_idx[icc_pkg::IDX_W-1:0] : off[6:2];

  assign ctl.clear  = (state == S_EXEC);
  assign ctl.sample = (state == S_SCAN) && pv;
  assign ctl.addr   = paddr;
  assign ctl.cand   = line_mask[paddr] & enable_mask[paddr] & ~in_service[paddr];

  icc_prio_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (off[6:2]),
    .wdata (wdat),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  icc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .prio      (ram_rdata),
    .threshold (threshold),
    .best      (best),
    .qual_cnt  (qual_cnt)
  );

  // Input word capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op   <= operation;
      off  <= offset;
      wdat <= write_data;
      src  <= source;
      lvl  <= level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      enable_mask <= '0;
      threshold   <= '0;
      in_service  <= '0;
      line_mask   <= '0;
      issue_idx   <= '0;
      pv          <= 1'b0;
      paddr       <= '0;
      rdata       <= '0;
      out_valid   <= 1'b0;
      read_data   <= '0;
      irq_pending <= 1'b0;
    end else begin
      // drop a taken word unless the finish step reloads it this cycle
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          issue_idx <= icc_pkg::CNT_W'(1);
          pv        <= 1'b0;
          case (op)
            icc_pkg::OP_READ: begin
              state <= prio_off ? S_PRD : S_SCAN;
              if (off == icc_pkg::OFF_PENDING) begin
                rdata <= line_mask;
              end else if (off == icc_pkg::OFF_ENABLE) begin
                rdata <= enable_mask;
              end else if (off == icc_pkg::OFF_THRESHOLD) begin
                rdata <= threshold;
              end else begin
                rdata <= '0;
              end
            end
            icc_pkg::OP_WRITE: begin
              state <= S_SCAN;
              rdata <= '0;
              if (off == icc_pkg::OFF_ENABLE) begin
                enable_mask <= wdat;
              end else if (off == icc_pkg::OFF_THRESHOLD) begin
                threshold <= wdat;
              end else if (off == icc_pkg::OFF_CLAIM) begin
                in_service <= in_service & ~(32'd1 << wdat[4:0]);
              end
            end
            icc_pkg::OP_LINE: begin
              state          <= S_SCAN;
              rdata          <= '0;
              line_mask[src] <= lvl;
            end
            default: begin
              state <= S_SCAN;
              rdata <= '0;
            end
          endcase
        end
        S_PRD: begin
          rdata <= ram_rdata;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (issue_more) begin
            pv        <= 1'b1;
            paddr     <= issue_idx[icc_pkg::IDX_W-1:0];
            issue_idx <= issue_idx + icc_pkg::CNT_W'(1);
          end else begin
            // last source is sampled this cycle
            pv    <= 1'b0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (is_claim) begin
              read_data <= {27'd0, best};
              if (best != '0) begin
                in_service  <= in_service | (32'd1 << best);
                irq_pending <= (qual_cnt == 2'd2);
              end else begin
                irq_pending <= 1'b0;
              end
            end else begin
              read_data   <= rdata;
              irq_pending <= (qual_cnt != 2'd0);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The walk never runs past the last source
  assert property (@(posedge clk) disable iff (rst)
    issue_idx <= icc_pkg::CNT_W'(icc_pkg::NUM_SOURCES))
    else $error("scan index past last source");

  // A qualifying source always leaves a winner
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && (qual_cnt != 2'd0) |-> (best != '0))
    else $error("qualifying source without a winner");

  // The winner is never a source already in service
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && (best != '0) |-> !in_service[best])
    else $error("claim winner already in service");

  // Finishing with a free output register presents a word next cycle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && out_free |=> out_valid && (state == S_IDLE))
    else $error("result not presented after walk");

  // No RAM write happens during the walk, while the read port is scanning
  assert property (@(posedge clk) disable iff (rst)
    !(ram_we && (state == S_SCAN)))
    else $error("priority write during walk");

endmodule
